### design/lpc_pkg.sv
package lpc_pkg;

    // Opcodes of an input transaction.
    localparam logic [1:0] OP_RAW   = 2'd0;
    localparam logic [1:0] OP_LEVEL = 2'd1;
    localparam logic [1:0] OP_HSV   = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_LED_COUNT  = 2'd0;
    localparam logic [1:0] REG_BRIGHTNESS = 2'd1;
    localparam logic [1:0] REG_GAMMA_EN   = 2'd2;

    localparam logic [7:0] FULL_SCALE = 8'd255;

    typedef struct packed {
        logic [15:0] led_count;
        logic [7:0]  brightness;
        logic        gamma_en;
    } cfg_t;

    typedef struct packed {
        logic [15:0] index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } pixel_t;

    // Rainbow wheel, red row.
    localparam logic [7:0] WHEEL_R [256] = '{
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd253, 8'd247, 8'd241, 8'd235, 8'd229, 8'd223, 8'd217,
        8'd211, 8'd205, 8'd199, 8'd193, 8'd187, 8'd181, 8'd175, 8'd169, 8'd163, 8'd157,
        8'd151, 8'd145, 8'd139, 8'd133, 8'd128, 8'd122, 8'd116, 8'd110, 8'd104, 8'd98,
        8'd92,  8'd86,  8'd80,  8'd74,  8'd68,  8'd62,  8'd56,  8'd50,  8'd44,  8'd38,
        8'd32,  8'd26,  8'd20,  8'd14,  8'd8,   8'd2,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd2,   8'd8,   8'd14,  8'd20,  8'd26,  8'd32,  8'd38,  8'd44,  8'd50,
        8'd56,  8'd62,  8'd68,  8'd74,  8'd80,  8'd86,  8'd92,  8'd98,  8'd104, 8'd110,
        8'd116, 8'd122, 8'd128, 8'd133, 8'd139, 8'd145, 8'd151, 8'd157, 8'd163, 8'd169,
        8'd175, 8'd181, 8'd187, 8'd193, 8'd199, 8'd205, 8'd211, 8'd217, 8'd223, 8'd229,
        8'd235, 8'd241, 8'd247, 8'd253, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255
    };

    // Rainbow wheel, green row.
    localparam logic [7:0] WHEEL_G [256] = '{
        8'd0,   8'd6,   8'd12,  8'd18,  8'd24,  8'd30,  8'd36,  8'd42,  8'd48,  8'd54,
        8'd60,  8'd66,  8'd72,  8'd78,  8'd84,  8'd90,  8'd96,  8'd102, 8'd108, 8'd114,
        8'd120, 8'd126, 8'd131, 8'd137, 8'd143, 8'd149, 8'd155, 8'd161, 8'd167, 8'd173,
        8'd179, 8'd185, 8'd191, 8'd197, 8'd203, 8'd209, 8'd215, 8'd221, 8'd227, 8'd233,
        8'd239, 8'd245, 8'd251, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd249,
        8'd243, 8'd237, 8'd231, 8'd225, 8'd219, 8'd213, 8'd207, 8'd201, 8'd195, 8'd189,
        8'd183, 8'd177, 8'd171, 8'd165, 8'd159, 8'd153, 8'd147, 8'd141, 8'd135, 8'd129,
        8'd124, 8'd118, 8'd112, 8'd106, 8'd100, 8'd94,  8'd88,  8'd82,  8'd76,  8'd70,
        8'd64,  8'd58,  8'd52,  8'd46,  8'd40,  8'd34,  8'd28,  8'd22,  8'd16,  8'd10,
        8'd4,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0
    };

    // Rainbow wheel, blue row.
    localparam logic [7:0] WHEEL_B [256] = '{
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd4,   8'd10,  8'd16,  8'd22,
        8'd28,  8'd34,  8'd40,  8'd46,  8'd52,  8'd58,  8'd64,  8'd70,  8'd76,  8'd82,
        8'd88,  8'd94,  8'd100, 8'd106, 8'd112, 8'd118, 8'd124, 8'd129, 8'd135, 8'd141,
        8'd147, 8'd153, 8'd159, 8'd165, 8'd171, 8'd177, 8'd183, 8'd189, 8'd195, 8'd201,
        8'd207, 8'd213, 8'd219, 8'd225, 8'd231, 8'd237, 8'd243, 8'd249, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
        8'd255, 8'd255, 8'd255, 8'd255, 8'd251, 8'd245, 8'd239, 8'd233, 8'd227, 8'd221,
        8'd215, 8'd209, 8'd203, 8'd197, 8'd191, 8'd185, 8'd179, 8'd173, 8'd167, 8'd161,
        8'd155, 8'd149, 8'd143, 8'd137, 8'd131, 8'd126, 8'd120, 8'd114, 8'd108, 8'd102,
        8'd96,  8'd90,  8'd84,  8'd78,  8'd72,  8'd66,  8'd60,  8'd54,  8'd48,  8'd42,
        8'd36,  8'd30,  8'd24,  8'd18,  8'd12,  8'd6
    };

    localparam logic [7:0] GAMMA [256] = '{
        8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
        8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
        8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd3,
        8'd3,   8'd3,   8'd3,   8'd3,   8'd4,   8'd4,   8'd4,   8'd5,
        8'd5,   8'd5,   8'd5,   8'd5,   8'd6,   8'd6,   8'd6,   8'd6,
        8'd7,   8'd7,   8'd7,   8'd8,   8'd8,   8'd8,   8'd8,   8'd8,
        8'd9,   8'd10,  8'd10,  8'd10,  8'd10,  8'd11,  8'd11,  8'd12,
        8'd12,  8'd12,  8'd12,  8'd13,  8'd13,  8'd13,  8'd14,  8'd14,
        8'd15,  8'd15,  8'd15,  8'd16,  8'd17,  8'd17,  8'd17,  8'd17,
        8'd18,  8'd18,  8'd19,  8'd20,  8'd20,  8'd20,  8'd20,  8'd21,
        8'd22,  8'd22,  8'd23,  8'd23,  8'd23,  8'd24,  8'd25,  8'd25,
        8'd26,  8'd26,  8'd27,  8'd27,  8'd28,  8'd28,  8'd29,  8'd30,
        8'd30,  8'd31,  8'd31,  8'd32,  8'd33,  8'd33,  8'd34,  8'd35,
        8'd35,  8'd36,  8'd37,  8'd37,  8'd38,  8'd38,  8'd39,  8'd40,
        8'd41,  8'd41,  8'd42,  8'd43,  8'd44,  8'd45,  8'd45,  8'd46,
        8'd47,  8'd47,  8'd48,  8'd49,  8'd50,  8'd51,  8'd52,  8'd53,
        8'd54,  8'd54,  8'd55,  8'd56,  8'd56,  8'd57,  8'd58,  8'd59,
        8'd60,  8'd61,  8'd62,  8'd63,  8'd64,  8'd65,  8'd66,  8'd67,
        8'd68,  8'd69,  8'd69,  8'd70,  8'd71,  8'd73,  8'd74,  8'd75,
        8'd76,  8'd77,  8'd78,  8'd79,  8'd80,  8'd81,  8'd82,  8'd84,
        8'd85,  8'd86,  8'd87,  8'd89,  8'd90,  8'd91,  8'd93,  8'd94,
        8'd95,  8'd96,  8'd97,  8'd98,  8'd100, 8'd101, 8'd102, 8'd103,
        8'd105, 8'd106, 8'd108, 8'd109, 8'd110, 8'd111, 8'd113, 8'd115,
        8'd117, 8'd118, 8'd119, 8'd121, 8'd122, 8'd123, 8'd124, 8'd127,
        8'd128, 8'd130, 8'd131, 8'd133, 8'd134, 8'd136, 8'd137, 8'd139,
        8'd140, 8'd143, 8'd145, 8'd146, 8'd147, 8'd148, 8'd151, 8'd153,
        8'd154, 8'd156, 8'd158, 8'd159, 8'd162, 8'd163, 8'd165, 8'd167,
        8'd169, 8'd171, 8'd173, 8'd174, 8'd176, 8'd179, 8'd180, 8'd182,
        8'd185, 8'd186, 8'd188, 8'd190, 8'd192, 8'd194, 8'd196, 8'd199,
        8'd201, 8'd202, 8'd205, 8'd207, 8'd209, 8'd211, 8'd214, 8'd216,
        8'd218, 8'd220, 8'd223, 8'd225, 8'd226, 8'd230, 8'd231, 8'd235,
        8'd236, 8'd240, 8'd241, 8'd245, 8'd246, 8'd250, 8'd251, 8'd255
    };

    // 8-bit fixed-point scale: (c * k) >> 8.
    function automatic logic [7:0] scale8(input logic [7:0] c, input logic [7:0] k);
        logic [15:0] prod;
        prod = c * k;
        return prod[15:8];
    endfunction

endpackage

### design/lpc_cfg_regs.sv
module lpc_cfg_regs
    import lpc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    output cfg_t        cfg
);

    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // Brightness and gamma keep only the low bits of cfg_data; the unused index is ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.led_count  <= 16'd0;
            cfg_reg.brightness <= FULL_SCALE;
            cfg_reg.gamma_en   <= 1'b1;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_LED_COUNT:  cfg_reg.led_count  <= cfg_data;
                REG_BRIGHTNESS: cfg_reg.brightness <= cfg_data[7:0];
                REG_GAMMA_EN:   cfg_reg.gamma_en   <= cfg_data[0];
                default: ;
            endcase
        end
    end

endmodule

### design/lpc_color_stages.sv
module lpc_color_stages
    import lpc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [15:0] led_count,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] in_index,
    input  logic [1:0]  in_opcode,
    input  logic [7:0]  in_a,
    input  logic [7:0]  in_b,
    input  logic [7:0]  in_c,
    input  logic [7:0]  in_level,
    output logic        out_valid,
    input  logic        out_ready,
    output pixel_t      out_pixel
);

    // Stage 1: base color from raw, level-scaled or wheel lookup.
    logic        v1_reg, v1_next;
    pixel_t      p1_reg, p1_next;
    logic [7:0]  sat1_reg, val1_reg;
    logic        hsv1_reg;
    // Stage 2: value scaling and the saturation mix term.
    logic        v2_reg;
    pixel_t      p2_reg, p2_next;
    logic [7:0]  sat2_reg;
    logic [15:0] mix2_reg, mix2_next;
    logic        mix_on2_reg, mix_on2_next;
    // Stage 3: saturation blend.
    logic        v3_reg;
    pixel_t      p3_reg, p3_next;

    logic        en1, en2, en3, keep;
    logic [7:0]  inv_sat;
    logic [16:0] sum_r, sum_g, sum_b;

    assign en3      = !v3_reg || out_ready;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    assign keep    = (in_index < led_count) &&
                     (in_opcode == OP_RAW || in_opcode == OP_LEVEL || in_opcode == OP_HSV);
    assign v1_next = in_valid && keep;

    always_comb begin
        p1_next.index = in_index;
        case (in_opcode)
            OP_RAW: begin
                p1_next.red   = in_a;
                p1_next.green = in_b;
                p1_next.blue  = in_c;
            end
            OP_LEVEL: begin
                p1_next.red   = scale8(in_a, in_level);
                p1_next.green = scale8(in_b, in_level);
                p1_next.blue  = scale8(in_c, in_level);
            end
            default: begin
                p1_next.red   = WHEEL_R[in_a];
                p1_next.green = WHEEL_G[in_a];
                p1_next.blue  = WHEEL_B[in_a];
            end
        endcase
    end

    always_comb begin
        p2_next = p1_reg;
        if (hsv1_reg && val1_reg != FULL_SCALE) begin
            p2_next.red   = scale8(p1_reg.red, val1_reg);
            p2_next.green = scale8(p1_reg.green, val1_reg);
            p2_next.blue  = scale8(p1_reg.blue, val1_reg);
        end
        inv_sat      = FULL_SCALE - sat1_reg;
        mix2_next    = val1_reg * inv_sat;
        mix_on2_next = hsv1_reg && sat1_reg != FULL_SCALE;
    end

    // The blend never exceeds 255 * v, so bits [15:8] hold the whole result.
    always_comb begin
        sum_r   = {9'd0, p2_reg.red}   * {9'd0, sat2_reg} + {1'b0, mix2_reg};
        sum_g   = {9'd0, p2_reg.green} * {9'd0, sat2_reg} + {1'b0, mix2_reg};
        sum_b   = {9'd0, p2_reg.blue}  * {9'd0, sat2_reg} + {1'b0, mix2_reg};
        p3_next = p2_reg;
        if (mix_on2_reg) begin
            p3_next.red   = sum_r[15:8];
            p3_next.green = sum_g[15:8];
            p3_next.blue  = sum_b[15:8];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= v1_next;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            p1_reg   <= p1_next;
            sat1_reg <= in_b;
            val1_reg <= in_c;
            hsv1_reg <= (in_opcode == OP_HSV);
        end
        if (en2) begin
            p2_reg      <= p2_next;
            sat2_reg    <= sat1_reg;
            mix2_reg    <= mix2_next;
            mix_on2_reg <= mix_on2_next;
        end
        if (en3) begin
            p3_reg <= p3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_pixel = p3_reg;

endmodule

### design/lpc_output_stages.sv
module lpc_output_stages
    import lpc_pkg::*;
(
    input  logic   aclk,
    input  logic   aresetn,
    input  cfg_t   cfg,
    input  logic   in_valid,
    output logic   in_ready,
    input  pixel_t in_pixel,
    output logic   out_valid,
    input  logic   out_ready,
    output pixel_t out_pixel
);

    logic   v4_reg, v5_reg;
    pixel_t p4_reg, p4_next, p5_reg, p5_next;
    logic   en4, en5;

    assign en5      = !v5_reg || out_ready;
    assign en4      = !v4_reg || en5;
    assign in_ready = en4;

    // Global brightness, skipped at full scale.
    always_comb begin
        p4_next = in_pixel;
        if (cfg.brightness != FULL_SCALE) begin
            p4_next.red   = scale8(in_pixel.red, cfg.brightness);
            p4_next.green = scale8(in_pixel.green, cfg.brightness);
            p4_next.blue  = scale8(in_pixel.blue, cfg.brightness);
        end
    end

    always_comb begin
        p5_next = p4_reg;
        if (cfg.gamma_en) begin
            p5_next.red   = GAMMA[p4_reg.red];
            p5_next.green = GAMMA[p4_reg.green];
            p5_next.blue  = GAMMA[p4_reg.blue];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (en4) v4_reg <= in_valid;
            if (en5) v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en4) p4_reg <= p4_next;
        if (en5) p5_reg <= p5_next;
    end

    assign out_valid = v5_reg;
    assign out_pixel = p5_reg;

endmodule

### design/led_pixel_color_pipeline_top.sv
// Channel   | Direction | Handshake           | Payload
// ----------+-----------+---------------------+---------------------------------------------
// s_ input  | in        | s_valid / s_ready   | pix_index, opcode, channel_a/b/c, level
// m_ result | out       | m_valid / m_ready   | out_index, out_green, out_red, out_blue
// cfg write | in        | cfg_valid/cfg_ready | cfg_index (0 count, 1 brightness, 2 gamma)
//
// One pixel transaction is accepted per cycle while s_ready is high and passes five
// register stages to the m_ side. Each stage holds 8x8 multiplies or 256-entry table
// reads. Reset (aresetn low, synchronous) empties all stages and sets LED count 0,
// brightness 255 and gamma on; writes are always ready.
// A stall on m_ready holds each occupied stage while empty stages keep filling, so no
// transaction is lost or repeated; a dropped pixel only leaves an empty slot behind.
module led_pixel_color_pipeline_top
    import lpc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_pix_index,
    input  logic [1:0]  s_opcode,
    input  logic [7:0]  s_channel_a,
    input  logic [7:0]  s_channel_b,
    input  logic [7:0]  s_channel_c,
    input  logic [7:0]  s_level,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_out_index,
    output logic [7:0]  m_out_green,
    output logic [7:0]  m_out_red,
    output logic [7:0]  m_out_blue
);

    cfg_t   cfg;
    logic   mid_valid;
    logic   mid_ready;
    pixel_t mid_pixel;
    pixel_t final_pixel;

    // Configuration registers. The user must issue writes only while the pipeline is empty;
    // this block does not enforce it, and the stages read these settings directly.
    lpc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Stages one to three: range check and opcode decode, value scaling, saturation.
    lpc_color_stages u_color (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .led_count (cfg.led_count),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_index  (s_pix_index),
        .in_opcode (s_opcode),
        .in_a      (s_channel_a),
        .in_b      (s_channel_b),
        .in_c      (s_channel_c),
        .in_level  (s_level),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .out_pixel (mid_pixel)
    );

    // Stages four and five: global brightness and gamma correction.
    lpc_output_stages u_output (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .in_valid  (mid_valid),
        .in_ready  (mid_ready),
        .in_pixel  (mid_pixel),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_pixel (final_pixel)
    );

    // Bytes leave in the strip's wire order: green, red, blue.
    assign m_out_index = final_pixel.index;
    assign m_out_green = final_pixel.green;
    assign m_out_red   = final_pixel.red;
    assign m_out_blue  = final_pixel.blue;

endmodule
